// ===== design/fsp_pkg.sv =====
// ----------------------------------------------------------------------------
// fsp_pkg
// Shared types, character codes and lookup functions for the format
// specifier parser.
// ----------------------------------------------------------------------------
package fsp_pkg;

  localparam int DEF_POSITION_BITS = 16;
  localparam int DEF_NUMBER_BITS   = 16;

  // Character codes
  localparam logic [7:0] CH_PERCENT = 8'h25;  // '%'
  localparam logic [7:0] CH_DASH    = 8'h2D;  // '-'
  localparam logic [7:0] CH_PLUS    = 8'h2B;  // '+'
  localparam logic [7:0] CH_SPACE   = 8'h20;  // ' '
  localparam logic [7:0] CH_HASH    = 8'h23;  // '#'
  localparam logic [7:0] CH_ZERO    = 8'h30;  // '0'
  localparam logic [7:0] CH_ONE     = 8'h31;  // '1'
  localparam logic [7:0] CH_NINE    = 8'h39;  // '9'
  localparam logic [7:0] CH_STAR    = 8'h2A;  // '*'
  localparam logic [7:0] CH_DOT     = 8'h2E;  // '.'
  localparam logic [7:0] CH_LOW_H   = 8'h68;  // 'h'
  localparam logic [7:0] CH_LOW_L   = 8'h6C;  // 'l'
  localparam logic [7:0] CH_LOW_J   = 8'h6A;  // 'j'
  localparam logic [7:0] CH_LOW_Z   = 8'h7A;  // 'z'
  localparam logic [7:0] CH_LOW_T   = 8'h74;  // 't'
  localparam logic [7:0] CH_UP_L    = 8'h4C;  // 'L'

  // Flag bit values
  localparam logic [4:0] FLAG_NONE  = 5'b00000;
  localparam logic [4:0] FLAG_DASH  = 5'b00001;
  localparam logic [4:0] FLAG_PLUS  = 5'b00010;
  localparam logic [4:0] FLAG_SPACE = 5'b00100;
  localparam logic [4:0] FLAG_HASH  = 5'b01000;
  localparam logic [4:0] FLAG_ZERO  = 5'b10000;

  // Length modifier codes
  localparam logic [3:0] LC_NONE = 4'd0;
  localparam logic [3:0] LC_H    = 4'd1;
  localparam logic [3:0] LC_HH   = 4'd2;
  localparam logic [3:0] LC_L    = 4'd3;
  localparam logic [3:0] LC_LL   = 4'd4;
  localparam logic [3:0] LC_J    = 4'd5;
  localparam logic [3:0] LC_Z    = 4'd6;
  localparam logic [3:0] LC_T    = 4'd7;
  localparam logic [3:0] LC_BIGL = 4'd8;

  localparam logic [7:0]  LEN_MAX   = 8'hFF;
  localparam logic [15:0] FIELD_MAX = 16'hFFFF;

  typedef enum logic [9:0] {
    PH_SCAN  = 10'b00_0000_0001,
    PH_PCT   = 10'b00_0000_0010,
    PH_FLAGS = 10'b00_0000_0100,
    PH_WIDTH = 10'b00_0000_1000,
    PH_AFTW  = 10'b00_0001_0000,
    PH_DOT   = 10'b00_0010_0000,
    PH_PREC  = 10'b00_0100_0000,
    PH_AFTP  = 10'b00_1000_0000,
    PH_MOD2  = 10'b01_0000_0000,
    PH_CONV  = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic       done;
    logic [7:0] len_count;
    logic [4:0] flags;
    logic       width_star;
    logic       prec_star;
    logic [3:0] length_code;
  } fsp_ctrl_t;

  localparam fsp_ctrl_t CTRL_RESET = '{
    phase: PH_SCAN, done: 1'b0, len_count: 8'd0, flags: FLAG_NONE,
    width_star: 1'b0, prec_star: 1'b0, length_code: LC_NONE
  };

  typedef struct packed {
    logic        found;
    logic [15:0] position;
    logic [7:0]  spec_length;
    logic [4:0]  flags;
    logic [15:0] width;
    logic        width_star;
    logic [15:0] precision;
    logic        precision_star;
    logic [3:0]  length_code;
    logic [7:0]  conversion;
  } fsp_result_t;

  function automatic logic [4:0] flag_of(input logic [7:0] c);
    logic [4:0] f;
    case (c)
      CH_DASH:  f = FLAG_DASH;
      CH_PLUS:  f = FLAG_PLUS;
      CH_SPACE: f = FLAG_SPACE;
      CH_HASH:  f = FLAG_HASH;
      CH_ZERO:  f = FLAG_ZERO;
      default:  f = FLAG_NONE;
    endcase
    return f;
  endfunction

  function automatic logic [3:0] modifier_of(input logic [7:0] c);
    logic [3:0] m;
    case (c)
      CH_LOW_H: m = LC_H;
      CH_LOW_L: m = LC_L;
      CH_LOW_J: m = LC_J;
      CH_LOW_Z: m = LC_Z;
      CH_LOW_T: m = LC_T;
      CH_UP_L:  m = LC_BIGL;
      default:  m = LC_NONE;
    endcase
    return m;
  endfunction

endpackage

// ===== design/fsp_if.sv =====
// ----------------------------------------------------------------------------
// fsp_if
// Valid/ready channels: character beats in, specifier result beats out.
// ----------------------------------------------------------------------------
interface fsp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, ch, last, input ready);
  modport sink   (input valid, ch, last, output ready);
endinterface

interface fsp_spec_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] position;
  logic [7:0]  spec_length;
  logic [4:0]  flags;
  logic [15:0] width;
  logic        width_star;
  logic [15:0] precision;
  logic        precision_star;
  logic [3:0]  length_code;
  logic [7:0]  conversion;

  modport source (output valid, found, position, spec_length, flags, width, width_star,
                  precision, precision_star, length_code, conversion, input ready);
  modport sink   (input valid, found, position, spec_length, flags, width, width_star,
                  precision, precision_star, length_code, conversion, output ready);
endinterface

// ===== design/fsp_step.sv =====
// ----------------------------------------------------------------------------
// fsp_step
// Next-state and result logic for one character of the format string.
// ----------------------------------------------------------------------------
module fsp_step #(
  parameter int POSITION_BITS = 16,
  parameter int NUMBER_BITS   = 16
) (
  input  fsp_pkg::fsp_ctrl_t       ctrl,
  input  logic [POSITION_BITS-1:0] char_pos,
  input  logic [POSITION_BITS-1:0] start_pos,
  input  logic [NUMBER_BITS-1:0]   width_val,
  input  logic [NUMBER_BITS-1:0]   prec_val,
  input  logic [7:0]               ch,
  input  logic                     last,
  output fsp_pkg::fsp_ctrl_t       ctrl_next,
  output logic [POSITION_BITS-1:0] char_pos_next,
  output logic [POSITION_BITS-1:0] start_pos_next,
  output logic [NUMBER_BITS-1:0]   width_val_next,
  output logic [NUMBER_BITS-1:0]   prec_val_next,
  output logic                     emit,
  output fsp_pkg::fsp_result_t     result
);
  import fsp_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [NUMBER_BITS-1:0]   NUM_MAX = '1;

  // v*10 + d, saturating
  function automatic logic [NUMBER_BITS-1:0] accum(input logic [NUMBER_BITS-1:0] v,
                                                   input logic [3:0] d);
    logic [NUMBER_BITS+3:0] n;
    n = ({4'b0000, v} << 3) + ({4'b0000, v} << 1) + (NUMBER_BITS+4)'(d);
    return (|n[NUMBER_BITS+3:NUMBER_BITS]) ? NUM_MAX : n[NUMBER_BITS-1:0];
  endfunction

  function automatic logic [15:0] clamp_pos(input logic [POSITION_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'(FIELD_MAX)) ? FIELD_MAX : w[15:0];
  endfunction

  function automatic logic [15:0] clamp_num(input logic [NUMBER_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'(FIELD_MAX)) ? FIELD_MAX : w[15:0];
  endfunction

  logic [4:0]             flag;
  logic [3:0]             modc;
  logic                   is_digit;
  logic                   is_nz_digit;
  logic [NUMBER_BITS-1:0] acc_out;
  logic [NUMBER_BITS-1:0] digit_val;
  logic                   taken;
  logic                   spec_hit;
  logic                   at_flags;
  logic                   at_aftw;
  logic                   at_aftp;

  assign flag        = flag_of(ch);
  assign modc        = modifier_of(ch);
  assign is_digit    = ch inside {[CH_ZERO:CH_NINE]};
  assign is_nz_digit = ch inside {[CH_ONE:CH_NINE]};
  assign digit_val   = NUMBER_BITS'(ch[3:0]);
  // width and precision digits never arrive in the same beat: one shared unit
  assign acc_out     = accum((ctrl.phase == PH_PREC) ? prec_val : width_val, ch[3:0]);

  always_comb begin
    ctrl_next      = ctrl;
    char_pos_next  = (char_pos == POS_MAX) ? char_pos : char_pos + 1'b1;
    start_pos_next = start_pos;
    width_val_next = width_val;
    prec_val_next  = prec_val;
    taken          = 1'b0;
    spec_hit       = 1'b0;
    at_flags       = 1'b0;
    at_aftw        = 1'b0;
    at_aftp        = 1'b0;

    if (ctrl.done) begin
      // result already out; wait for end of string
    end else if (ctrl.phase == PH_SCAN) begin
      if (ch == CH_PERCENT) begin
        ctrl_next       = CTRL_RESET;
        ctrl_next.phase = PH_PCT;
        start_pos_next  = char_pos;
        width_val_next  = '0;
        prec_val_next   = '0;
      end
    end else begin
      if (ctrl.len_count != LEN_MAX) begin
        ctrl_next.len_count = ctrl.len_count + 8'd1;
      end

      // "%%" is a literal percent
      if (ctrl.phase == PH_PCT && ch == CH_PERCENT) begin
        ctrl_next.phase = PH_SCAN;
        taken = 1'b1;
      end

      at_flags = !taken && (ctrl.phase == PH_PCT || ctrl.phase == PH_FLAGS);
      if (at_flags) begin
        if (flag != FLAG_NONE) begin
          ctrl_next.flags = ctrl.flags | flag;
          ctrl_next.phase = PH_FLAGS;
          taken = 1'b1;
        end else if (ch == CH_STAR) begin
          ctrl_next.width_star = 1'b1;
          ctrl_next.phase = PH_AFTW;
          taken = 1'b1;
        end else if (is_nz_digit) begin
          width_val_next  = digit_val;
          ctrl_next.phase = PH_WIDTH;
          taken = 1'b1;
        end
      end

      if (!taken && ctrl.phase == PH_WIDTH && is_digit) begin
        width_val_next = acc_out;
        taken = 1'b1;
      end

      at_aftw = !taken && (at_flags || ctrl.phase == PH_WIDTH || ctrl.phase == PH_AFTW);
      if (at_aftw && ch == CH_DOT) begin
        ctrl_next.phase = PH_DOT;
        taken = 1'b1;
      end

      if (!taken && ctrl.phase == PH_DOT) begin
        if (ch == CH_STAR) begin
          ctrl_next.prec_star = 1'b1;
          ctrl_next.phase = PH_AFTP;
          taken = 1'b1;
        end else if (is_digit) begin
          prec_val_next   = digit_val;
          ctrl_next.phase = PH_PREC;
          taken = 1'b1;
        end
      end

      if (!taken && ctrl.phase == PH_PREC && is_digit) begin
        prec_val_next = acc_out;
        taken = 1'b1;
      end

      at_aftp = !taken && (at_aftw || ctrl.phase == PH_DOT || ctrl.phase == PH_PREC ||
                           ctrl.phase == PH_AFTP);
      if (at_aftp && modc != LC_NONE) begin
        ctrl_next.length_code = modc;
        ctrl_next.phase = (modc == LC_H || modc == LC_L) ? PH_MOD2 : PH_CONV;
        taken = 1'b1;
      end

      if (!taken && ctrl.phase == PH_MOD2) begin
        if (ch == CH_LOW_H && ctrl.length_code == LC_H) begin
          ctrl_next.length_code = LC_HH;
          ctrl_next.phase = PH_CONV;
          taken = 1'b1;
        end else if (ch == CH_LOW_L && ctrl.length_code == LC_L) begin
          ctrl_next.length_code = LC_LL;
          ctrl_next.phase = PH_CONV;
          taken = 1'b1;
        end
      end

      // anything left over is the conversion character
      if (!taken) begin
        spec_hit       = 1'b1;
        ctrl_next.done = 1'b1;
      end
    end

    emit                  = spec_hit;
    result.found          = 1'b1;
    result.position       = clamp_pos(start_pos_next);
    result.spec_length    = ctrl_next.len_count;
    result.flags          = ctrl_next.flags;
    result.width          = clamp_num(width_val_next);
    result.width_star     = ctrl_next.width_star;
    result.precision      = clamp_num(prec_val_next);
    result.precision_star = ctrl_next.prec_star;
    result.length_code    = ctrl_next.length_code;
    result.conversion     = ch;

    if (last) begin
      if (!spec_hit && !ctrl.done) begin
        emit = 1'b1;
        if (ctrl_next.phase == PH_SCAN) begin
          result = '0;
        end else begin
          // string ended inside the specifier
          result.conversion  = 8'd0;
          result.spec_length = (ctrl_next.len_count == LEN_MAX) ? LEN_MAX :
                               ctrl_next.len_count + 8'd1;
        end
      end
      ctrl_next      = CTRL_RESET;
      char_pos_next  = '0;
      start_pos_next = '0;
      width_val_next = '0;
      prec_val_next  = '0;
    end
  end

endmodule

// ===== design/format_specifier_parser.sv =====
// Pipeline: two register stages, input and result. An accepted character beat
//   is held in the input register, its result beat (if any) in the result one.
// Throughput: one character per cycle unless the result register stalls.
// Reset: synchronous rst clears both valid flags and returns the parser to
//   scanning for a percent sign at string offset zero.
// ----------------------------------------------------------------------------
// format_specifier_parser
// Streaming printf-style format specifier parser. Scans a byte stream for the
// first conversion specifier and reports its flags, width, precision, length
// modifier and conversion character as one result beat per string.
// ----------------------------------------------------------------------------
module format_specifier_parser #(
  parameter int POSITION_BITS = fsp_pkg::DEF_POSITION_BITS,
  parameter int NUMBER_BITS   = fsp_pkg::DEF_NUMBER_BITS
) (
  input logic         clk,
  input logic         rst,
  fsp_char_if.sink    chars,
  fsp_spec_if.source  specs
);
  import fsp_pkg::*;

  // Input register stage: holds one character beat.
  logic       in_valid;
  logic [7:0] in_ch;
  logic       in_last;

  // Parser state.
  fsp_ctrl_t                ctrl;
  logic [POSITION_BITS-1:0] char_pos;
  logic [POSITION_BITS-1:0] start_pos;
  logic [NUMBER_BITS-1:0]   width_val;
  logic [NUMBER_BITS-1:0]   prec_val;

  fsp_ctrl_t                ctrl_next;
  logic [POSITION_BITS-1:0] char_pos_next;
  logic [POSITION_BITS-1:0] start_pos_next;
  logic [NUMBER_BITS-1:0]   width_val_next;
  logic [NUMBER_BITS-1:0]   prec_val_next;

  // Result register stage.
  logic        out_valid;
  fsp_result_t out_res;

  logic        emit;
  fsp_result_t result;
  logic        advance;

  fsp_step #(
    .POSITION_BITS (POSITION_BITS),
    .NUMBER_BITS   (NUMBER_BITS)
  ) u_step (
    .ctrl           (ctrl),
    .char_pos       (char_pos),
    .start_pos      (start_pos),
    .width_val      (width_val),
    .prec_val       (prec_val),
    .ch             (in_ch),
    .last           (in_last),
    .ctrl_next      (ctrl_next),
    .char_pos_next  (char_pos_next),
    .start_pos_next (start_pos_next),
    .width_val_next (width_val_next),
    .prec_val_next  (prec_val_next),
    .emit           (emit),
    .result         (result)
  );

  // A held beat moves on unless it makes a result and the result register is
  // still full and stalled. Beats that produce nothing never wait.
  assign advance     = in_valid && (!emit || !out_valid || specs.ready);
  assign chars.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      ctrl      <= CTRL_RESET;
      char_pos  <= '0;
      start_pos <= '0;
      width_val <= '0;
      prec_val  <= '0;
    end else begin
      if (chars.ready) begin
        in_valid <= chars.valid;
      end
      if (advance) begin
        ctrl      <= ctrl_next;
        char_pos  <= char_pos_next;
        start_pos <= start_pos_next;
        width_val <= width_val_next;
        prec_val  <= prec_val_next;
      end
      if (advance && emit) begin
        out_valid <= 1'b1;
      end else if (specs.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      in_ch   <= chars.ch;
      in_last <= chars.last;
    end
    if (advance && emit) begin
      out_res <= result;
    end
  end

  assign specs.valid          = out_valid;
  assign specs.found          = out_res.found;
  assign specs.position       = out_res.position;
  assign specs.spec_length    = out_res.spec_length;
  assign specs.flags          = out_res.flags;
  assign specs.width          = out_res.width;
  assign specs.width_star     = out_res.width_star;
  assign specs.precision      = out_res.precision;
  assign specs.precision_star = out_res.precision_star;
  assign specs.length_code    = out_res.length_code;
  assign specs.conversion     = out_res.conversion;

endmodule
